@@ src/vtpp_pkg.sv @@
// ----------------------------------------------------------------------------
// vtpp_pkg: test pattern pixel package
// Types, frame geometry constants, colour table and shape helpers shared by
// the channel interfaces and the pattern pipeline.
// ----------------------------------------------------------------------------
package vtpp_pkg;

	typedef logic [9:0]  coord_t;
	typedef logic [31:0] frame_t;
	typedef logic [7:0]  chan_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} rgb_t;

	// frame geometry
	localparam coord_t FRAME_W   = 10'd800;
	localparam coord_t FRAME_H   = 10'd600;
	localparam coord_t HEADER_H  = 10'd82;
	localparam coord_t LOWER_TOP = 10'd362;

	// reciprocals for modulo by constant (quotient estimate is low by at most one)
	localparam logic [22:0] RECIP_680 = 23'd6316128;  // floor(2^32 / 680)
	localparam logic [23:0] RECIP_470 = 24'd9138228;  // floor(2^32 / 470)
	localparam logic [24:0] RECIP_240 = 25'd17895697; // floor(2^32 / 240)
	localparam logic [8:0]  RECIP_799 = 9'd328;       // floor(2^18 / 799)
	localparam logic [7:0]  RECIP_3   = 8'd171;       // exact /3 below 256, shift 9

	// colours
	localparam rgb_t HDR_BG     = '{8'd8, 8'd12, 8'd18};
	localparam rgb_t LOGO_GREY  = '{8'd245, 8'd245, 8'd245};
	localparam rgb_t HDR_GREEN  = '{8'd74, 8'd222, 8'd128};
	localparam rgb_t HDR_BLUE   = '{8'd70, 8'd160, 8'd255};
	localparam rgb_t HDR_YELLOW = '{8'd255, 8'd210, 8'd70};
	localparam rgb_t LOWER_BG   = '{8'd22, 8'd26, 8'd32};
	localparam rgb_t GRID_LINE  = '{8'd68, 8'd72, 8'd80};
	localparam rgb_t BLACK      = '{8'd0, 8'd0, 8'd0};
	localparam rgb_t WHITE      = '{8'd255, 8'd255, 8'd255};

	localparam rgb_t BAR_COLOURS [8] = '{
		'{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd0},
		'{8'd0, 8'd255, 8'd255},   '{8'd0, 8'd255, 8'd0},
		'{8'd255, 8'd0, 8'd255},   '{8'd255, 8'd0, 8'd0},
		'{8'd0, 8'd0, 8'd255},     '{8'd20, 8'd20, 8'd20}
	};

	// point inside a rectangle, end bounds exclusive
	function automatic logic in_rect(input coord_t px, input coord_t py,
			input coord_t x0, input coord_t x1, input coord_t y0, input coord_t y1);
		return (px >= x0) && (px < x1) && (py >= y0) && (py < y1);
	endfunction

	// signed 11-bit offset lies in [lo, hi)
	function automatic logic in_span(input logic [10:0] d, input coord_t lo,
			input coord_t hi);
		return !d[10] && (d[9:0] >= lo) && (d[9:0] < hi);
	endfunction

	// value is a multiple of 40 below 800
	function automatic logic on_grid40(input coord_t v);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 20; i++) begin
			hit = hit || (v == 10'(40 * i));
		end
		return hit;
	endfunction

	// column band index of the colour bars
	function automatic logic [2:0] bar_index(input coord_t px);
		logic [2:0] idx;
		idx = 3'd0;
		for (int k = 1; k < 8; k++) begin
			idx = idx + 3'(px >= 10'(100 * k));
		end
		return idx;
	endfunction

	// blocky logo letters in the header
	function automatic logic on_logo(input coord_t px, input coord_t py);
		logic hit;
		// H
		hit = in_rect(px, py, 10'd30, 10'd35, 10'd22, 10'd67) ||
			in_rect(px, py, 10'd55, 10'd60, 10'd22, 10'd67) ||
			in_rect(px, py, 10'd30, 10'd60, 10'd42, 10'd47);
		// D
		hit = hit || in_rect(px, py, 10'd70, 10'd75, 10'd22, 10'd67) ||
			in_rect(px, py, 10'd70, 10'd95, 10'd22, 10'd27) ||
			in_rect(px, py, 10'd70, 10'd95, 10'd62, 10'd67) ||
			in_rect(px, py, 10'd95, 10'd100, 10'd27, 10'd62);
		// M posts and diagonals
		hit = hit || in_rect(px, py, 10'd110, 10'd115, 10'd22, 10'd67) ||
			in_rect(px, py, 10'd135, 10'd140, 10'd22, 10'd67);
		for (int i = 0; i < 4; i++) begin
			hit = hit ||
				in_rect(px, py, 10'(115 + 5 * i), 10'(120 + 5 * i),
					10'(27 + 5 * i), 10'(32 + 5 * i)) ||
				in_rect(px, py, 10'(130 - 5 * i), 10'(135 - 5 * i),
					10'(27 + 5 * i), 10'(32 + 5 * i));
		end
		// I
		hit = hit || in_rect(px, py, 10'd150, 10'd180, 10'd22, 10'd27) ||
			in_rect(px, py, 10'd160, 10'd165, 10'd22, 10'd67) ||
			in_rect(px, py, 10'd150, 10'd180, 10'd62, 10'd67);
		return hit;
	endfunction

endpackage

@@ src/vtpp_ifs.sv @@
// ----------------------------------------------------------------------------
// vtpp channel interfaces
// Valid/ready channels for pixel coordinates, pixel colours and the mode
// register write.
// ----------------------------------------------------------------------------

// coordinate channel
interface vtpp_coord_if;
	logic              valid;
	logic              ready;
	vtpp_pkg::coord_t  pixel_x;
	vtpp_pkg::coord_t  pixel_y;
	vtpp_pkg::frame_t  frame_number;

	modport source (output valid, output pixel_x, output pixel_y, output frame_number,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input frame_number,
		output ready);
endinterface

// colour channel
interface vtpp_color_if;
	logic             valid;
	logic             ready;
	vtpp_pkg::chan_t  red;
	vtpp_pkg::chan_t  green;
	vtpp_pkg::chan_t  blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// mode register write channel
interface vtpp_cfg_if;
	logic valid;
	logic ready;
	logic pattern_mode;

	modport source (output valid, output pattern_mode, input ready);
	modport sink (input valid, input pattern_mode, output ready);
endinterface

@@ src/video_test_pattern_pixel.sv @@
// ----------------------------------------------------------------------------
// video_test_pattern_pixel: 800x600 test pattern colour generator
// Returns the RGB888 colour of one pixel of the test frame, with an optional
// frame-driven motion overlay.
// ----------------------------------------------------------------------------
// One coordinate is taken per clock and its colour leaves from the stage 7 register;
// the pipeline streams one pixel per cycle for as long as the colour side takes
// transfers. The latency is set by the modulo-by-constant chain on the frame
// number (multiply, reciprocal quotient, remainder, correction), which runs
// beside the shade divider for the grey ramp. Stalls on the colour side only
// hold the stages that are full, so empty stages keep taking coordinates.
// Pixels outside the 800x600 frame come out black. The mode register is taken
// by a transfer on cfg at any time; it must only change while no pixel is in
// flight.
module video_test_pattern_pixel (
	input  logic                clk,
	input  logic                arst_n,
	vtpp_cfg_if.sink            cfg,
	vtpp_coord_if.sink          coord,
	vtpp_color_if.source        color
);

	// mode register
	logic pattern_mode_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			pattern_mode_q <= cfg.pattern_mode;
		end
	end

	// stage valids and per-stage load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || color.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign coord.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= coord.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// stage 1: input register
	vtpp_pkg::coord_t x_s1, y_s1;
	vtpp_pkg::frame_t f_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1 <= coord.pixel_x;
			y_s1 <= coord.pixel_y;
			f_s1 <= coord.frame_number;
		end
	end

	// stage 2: scaled frame counts, ramp numerator, pulse
	vtpp_pkg::frame_t w9_s2, w5_s2, f_s2;
	logic [17:0]      xs_s2;
	vtpp_pkg::coord_t x_s2, y_s2;
	vtpp_pkg::chan_t  pulse_s2;
	logic [10:0]      p7;

	assign p7 = {f_s1[7:0], 3'b000} - {3'b000, f_s1[7:0]};

	always_ff @(posedge clk) begin
		if (en2) begin
			w9_s2    <= {f_s1[28:0], 3'b000} + f_s1;
			w5_s2    <= {f_s1[29:0], 2'b00} + f_s1;
			f_s2     <= f_s1;
			xs_s2    <= {x_s1, 8'h00} - {8'h00, x_s1};
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			pulse_s2 <= p7[7:0];
		end
	end

	// stage 3: reciprocal quotient estimates
	logic [63:0] prod9, prod5, prod240;
	logic [26:0] prods;
	logic [22:0] q9_s3;
	logic [23:0] q5_s3;
	logic [24:0] q240_s3;
	vtpp_pkg::chan_t  qs_s3;
	vtpp_pkg::frame_t w9_s3, w5_s3, f_s3;
	logic [17:0]      xs_s3;
	vtpp_pkg::coord_t x_s3, y_s3;
	vtpp_pkg::chan_t  pulse_s3;

	assign prod9   = {32'd0, w9_s2} * {41'd0, vtpp_pkg::RECIP_680};
	assign prod5   = {32'd0, w5_s2} * {40'd0, vtpp_pkg::RECIP_470};
	assign prod240 = {32'd0, f_s2} * {39'd0, vtpp_pkg::RECIP_240};
	assign prods   = {9'd0, xs_s2} * {18'd0, vtpp_pkg::RECIP_799};

	always_ff @(posedge clk) begin
		if (en3) begin
			q9_s3    <= prod9[54:32];
			q5_s3    <= prod5[55:32];
			q240_s3  <= prod240[56:32];
			qs_s3    <= prods[25:18];
			w9_s3    <= w9_s2;
			w5_s3    <= w5_s2;
			f_s3     <= f_s2;
			xs_s3    <= xs_s2;
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			pulse_s3 <= pulse_s2;
		end
	end

	// stage 4: raw remainders, each below twice its divisor
	vtpp_pkg::frame_t t9, t5, t240;
	logic [17:0]      ts;
	logic [10:0]      r9_s4;
	logic [9:0]       r5_s4;
	logic [8:0]       r240_s4;
	logic [10:0]      rs_s4;
	vtpp_pkg::chan_t  qs_s4;
	vtpp_pkg::coord_t x_s4, y_s4;
	vtpp_pkg::chan_t  pulse_s4;

	assign t9   = w9_s3 - {9'd0, q9_s3} * 32'd680;
	assign t5   = w5_s3 - {8'd0, q5_s3} * 32'd470;
	assign t240 = f_s3 - {7'd0, q240_s3} * 32'd240;
	assign ts   = xs_s3 - {10'd0, qs_s3} * 18'd799;

	always_ff @(posedge clk) begin
		if (en4) begin
			r9_s4    <= t9[10:0];
			r5_s4    <= t5[9:0];
			r240_s4  <= t240[8:0];
			rs_s4    <= ts[10:0];
			qs_s4    <= qs_s3;
			x_s4     <= x_s3;
			y_s4     <= y_s3;
			pulse_s4 <= pulse_s3;
		end
	end

	// stage 5: remainder correction and ramp shade
	logic [10:0]      c9;
	logic [9:0]       c5;
	logic [8:0]       c240;
	logic [9:0]       m9_s5;
	logic [8:0]       m5_s5;
	logic [7:0]       m240_s5;
	vtpp_pkg::chan_t  shade_s5;
	vtpp_pkg::coord_t x_s5, y_s5;
	vtpp_pkg::chan_t  pulse_s5;

	assign c9   = (r9_s4 >= 11'd680) ? r9_s4 - 11'd680 : r9_s4;
	assign c5   = (r5_s4 >= 10'd470) ? r5_s4 - 10'd470 : r5_s4;
	assign c240 = (r240_s4 >= 9'd240) ? r240_s4 - 9'd240 : r240_s4;

	always_ff @(posedge clk) begin
		if (en5) begin
			m9_s5    <= c9[9:0];
			m5_s5    <= c5[8:0];
			m240_s5  <= c240[7:0];
			shade_s5 <= qs_s4 + 8'(rs_s4 >= 11'd799);
			x_s5     <= x_s4;
			y_s5     <= y_s4;
			pulse_s5 <= pulse_s4;
		end
	end

	// stage 5 logic: base layers in painter's order
	vtpp_pkg::rgb_t   base;
	vtpp_pkg::coord_t ylow, ybox, xbox;
	logic             inf;
	logic [15:0]      div3;

	assign inf  = (x_s5 < vtpp_pkg::FRAME_W) && (y_s5 < vtpp_pkg::FRAME_H);
	assign ylow = y_s5 - vtpp_pkg::LOWER_TOP;
	assign ybox = y_s5 - 10'd396;
	assign xbox = x_s5 - 10'd36;
	assign div3 = {8'd0, m240_s5} * {8'd0, vtpp_pkg::RECIP_3};

	always_comb begin
		base = vtpp_pkg::BLACK;
		if (!inf) begin
			base = vtpp_pkg::BLACK;
		end else if (y_s5 < vtpp_pkg::HEADER_H) begin
			base = vtpp_pkg::HDR_BG;
			if (vtpp_pkg::on_logo(x_s5, y_s5)) base = vtpp_pkg::LOGO_GREY;
			if (vtpp_pkg::in_rect(x_s5, y_s5, 10'd300, 10'd520, 10'd26, 10'd36))
				base = vtpp_pkg::HDR_GREEN;
			if (vtpp_pkg::in_rect(x_s5, y_s5, 10'd300, 10'd620, 10'd44, 10'd54))
				base = vtpp_pkg::HDR_BLUE;
			if (vtpp_pkg::in_rect(x_s5, y_s5, 10'd300, 10'd450, 10'd62, 10'd72))
				base = vtpp_pkg::HDR_YELLOW;
		end else if (y_s5 < vtpp_pkg::LOWER_TOP) begin
			base = vtpp_pkg::BAR_COLOURS[vtpp_pkg::bar_index(x_s5)];
		end else begin
			base = vtpp_pkg::LOWER_BG;
			if (vtpp_pkg::on_grid40(x_s5) || vtpp_pkg::on_grid40(ylow))
				base = vtpp_pkg::GRID_LINE;
			if (y_s5 >= 10'd500 && y_s5 < 10'd556)
				base = '{shade_s5, shade_s5, shade_s5};
			if (vtpp_pkg::in_rect(x_s5, y_s5, 10'd30, 10'd250, 10'd390, 10'd462))
				base = vtpp_pkg::BLACK;
			if (vtpp_pkg::in_rect(x_s5, y_s5, 10'd36, 10'd244, 10'd396, 10'd456)) begin
				if (ybox[2:0] == 3'd0 || xbox[2:0] == 3'd0) base = vtpp_pkg::BLACK;
				else base = vtpp_pkg::WHITE;
			end
		end
	end

	// stage 6: base colour and overlay positions
	vtpp_pkg::rgb_t   base_s6;
	vtpp_pkg::coord_t bx_s6, by_s6, scan_s6, x_s6, y_s6;
	vtpp_pkg::chan_t  pulse_s6;
	logic             inf_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			base_s6  <= base;
			bx_s6    <= 10'd40 + m9_s5;
			by_s6    <= 10'd390 + {3'd0, div3[15:9]};
			scan_s6  <= 10'd82 + {1'b0, m5_s5};
			x_s6     <= x_s5;
			y_s6     <= y_s5;
			pulse_s6 <= pulse_s5;
			inf_s6   <= inf;
		end
	end

	// stage 6 logic: motion overlay on top of the base colour
	logic [10:0]     dx, dy, ds;
	logic [8:0]      lift;
	vtpp_pkg::rgb_t  pix;

	assign dx   = {1'b0, x_s6} - {1'b0, bx_s6};
	assign dy   = {1'b0, y_s6} - {1'b0, by_s6};
	assign ds   = {1'b0, y_s6} - {1'b0, scan_s6};
	assign lift = {1'b0, pulse_s6} + 9'd40;

	always_comb begin
		pix = base_s6;
		if (pattern_mode_q && inf_s6) begin
			if (vtpp_pkg::in_span(dx, 10'd0, 10'd96) && vtpp_pkg::in_span(dy, 10'd0, 10'd58))
				pix = vtpp_pkg::WHITE;
			if (vtpp_pkg::in_span(dx, 10'd6, 10'd90) && vtpp_pkg::in_span(dy, 10'd6, 10'd52))
				pix = vtpp_pkg::BLACK;
			if (vtpp_pkg::in_span(dx, 10'd14, 10'd82) &&
					vtpp_pkg::in_span(dy, 10'd14, 10'd44))
				pix = '{~pulse_s6, 8'd80 + {1'b0, pulse_s6[7:1]}, 8'd255};
			if (vtpp_pkg::in_span(ds, 10'd0, 10'd3))
				pix = vtpp_pkg::WHITE;
			if (vtpp_pkg::in_rect(x_s6, y_s6, 10'd640, 10'd768, 10'd24, 10'd68))
				pix = '{lift[8] ? 8'd255 : lift[7:0], 8'd255,
					8'd255 - {1'b0, pulse_s6[7:1]}};
		end
	end

	// stage 7: output register
	vtpp_pkg::rgb_t rgb_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			rgb_s7 <= pix;
		end
	end

	assign color.valid = v_s7;
	assign color.red   = rgb_s7.r;
	assign color.green = rgb_s7.g;
	assign color.blue  = rgb_s7.b;

	// an accepted coordinate always enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		coord.valid && coord.ready |=> v_s1)
		else $error("accepted coordinate lost at stage 1");

	// corrected remainders stay below their divisors
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (m9_s5 < 10'd680) && (m5_s5 < 9'd470) && (m240_s5 < 8'd240))
		else $error("modulo correction out of range");

	// without motion the output is the base colour
	a_static_base: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && en7 && !pattern_mode_q |=> rgb_s7 == $past(base_s6))
		else $error("static pattern altered by overlay");

endmodule
